@@ design/ocl_pkg.sv @@
// Shared types and constants for the ordered character list engine.
// No dependencies; imported by ocl_ram and ordered_char_list_engine.
package ocl_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 6;
  localparam int STAT_W = 2;
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  removed_count;
    logic [CHAR_W-1:0] list_char;
    logic              item_valid;
    logic              last;
  } res_t;

  function automatic res_t make_res(logic [STAT_W-1:0] status, logic [LEN_W-1:0] length,
                                    logic [LEN_W-1:0] removed, logic [CHAR_W-1:0] ch,
                                    logic valid, logic last);
    res_t r;
    r.status        = status;
    r.length        = length;
    r.removed_count = removed;
    r.list_char     = ch;
    r.item_valid    = valid;
    r.last          = last;
    return r;
  endfunction

endpackage

@@ design/ocl_ram.sv @@
// Character store: one write port, one read port, registered read data.
// Depends on ocl_pkg for the character width.
module ocl_ram #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ocl_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ocl_pkg::CHAR_W-1:0] rdata
);
  import ocl_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data, updated while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ordered_char_list_engine.sv @@
// Ordered character list engine: sequencer around a single character RAM.
// Depends on ocl_pkg and ocl_ram.
//
//  channel   handshake             fields
//  command   start / busy          op, value_char, position
//  result    result_valid strobe   status, length, removed_count, list_char,
//                                  item_valid, last
//
// Append, insert at the end, any dropped command and a dump of an empty list:
// result in the cycle after the command beat.
// Insert at position p below the length n: one RAM read and one write-back per
// moved character. Remove: one scan of the RAM read port. Dump: n results on
// consecutive cycles.
// busy falls at the edge that raises the final result strobe.
// Reset clears the length; RAM contents are undefined and never read unwritten.
// Results cannot be stalled: each strobe lasts exactly one cycle.
module ordered_char_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic [ocl_pkg::CHAR_W-1:0] value_char,
  input  logic [ocl_pkg::POS_W-1:0]  position,
  output logic                       result_valid,
  output logic [ocl_pkg::STAT_W-1:0] status,
  output logic [ocl_pkg::LEN_W-1:0]  length,
  output logic [ocl_pkg::LEN_W-1:0]  removed_count,
  output logic [ocl_pkg::CHAR_W-1:0] list_char,
  output logic                       item_valid,
  output logic                       last
);
  import ocl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_REM, S_DUMP} state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     kept;
  logic [AW-1:0]     pos_r;
  logic [CHAR_W-1:0] ch_r;
  logic              pend;
  logic [AW-1:0]     pend_a;
  res_t              res;

  logic              full;
  logic              more;
  logic              rd_en;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [CHAR_W-1:0] rdata;

  ocl_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);
  assign full = (count == CAP);

  // drive RAM ports from the sequencer state
  always_comb begin
    more  = 1'b0;
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = value_char;
    case (state)
      S_IDLE: begin
        if (start && !full) begin
          if (op_t'(op) == OP_APPEND ||
              (op_t'(op) == OP_INSERT && position == POS_W'(count))) begin
            we    = 1'b1;
            waddr = AW'(count);
          end
        end
      end
      S_INS: begin
        more  = (idx != CW'(pos_r));
        rd_en = more;
        raddr = AW'(idx - 1'b1);
        if (pend) begin
          we    = 1'b1;
          waddr = AW'(pend_a + 1'b1);
          wdata = rdata;
        end else if (!more) begin
          we    = 1'b1;
          waddr = pos_r;
          wdata = ch_r;
        end
      end
      S_REM: begin
        more  = (idx != count);
        rd_en = more;
        raddr = AW'(idx);
        if (pend && rdata != ch_r) begin
          we    = 1'b1;
          waddr = AW'(kept);
          wdata = rdata;
        end
      end
      S_DUMP: begin
        more  = (idx != count);
        rd_en = more;
        raddr = AW'(idx);
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  // sequencer, list length and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pend         <= rd_en;
      pend_a       <= raddr;
      case (state)
        S_IDLE: begin
          if (start) begin
            ch_r <= value_char;
            kept <= '0;
            case (op_t'(op))
              OP_APPEND: begin
                result_valid <= 1'b1;
                if (full) begin
                  res <= make_res(ST_FULL, LEN_W'(count), '0, '0, 1'b0, 1'b1);
                end else begin
                  count <= count + 1'b1;
                  res   <= make_res(ST_OK, LEN_W'(count + 1'b1), '0, '0, 1'b0, 1'b1);
                end
              end
              OP_INSERT: begin
                if (full) begin
                  result_valid <= 1'b1;
                  res <= make_res(ST_FULL, LEN_W'(count), '0, '0, 1'b0, 1'b1);
                end else if (position > POS_W'(count)) begin
                  result_valid <= 1'b1;
                  res <= make_res(ST_RANGE, LEN_W'(count), '0, '0, 1'b0, 1'b1);
                end else if (position == POS_W'(count)) begin
                  result_valid <= 1'b1;
                  count <= count + 1'b1;
                  res   <= make_res(ST_OK, LEN_W'(count + 1'b1), '0, '0, 1'b0, 1'b1);
                end else begin
                  state <= S_INS;
                  idx   <= count;
                  pos_r <= AW'(position);
                end
              end
              OP_REMOVE: begin
                state <= S_REM;
                idx   <= '0;
              end
              OP_DUMP: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  res <= make_res(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                  state <= S_DUMP;
                  idx   <= '0;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        // shift characters up by one, top first, then drop the new one in
        S_INS: begin
          if (more) begin
            idx <= idx - 1'b1;
          end else if (!pend) begin
            count        <= count + 1'b1;
            result_valid <= 1'b1;
            res   <= make_res(ST_OK, LEN_W'(count + 1'b1), '0, '0, 1'b0, 1'b1);
            state <= S_IDLE;
          end
        end
        // compact the kept characters towards the bottom
        S_REM: begin
          if (more) begin
            idx <= idx + 1'b1;
          end
          if (pend && rdata != ch_r) begin
            kept <= kept + 1'b1;
          end
          if (!more && !pend) begin
            count        <= kept;
            result_valid <= 1'b1;
            res   <= make_res(ST_OK, LEN_W'(kept), LEN_W'(count - kept), '0, 1'b0, 1'b1);
            state <= S_IDLE;
          end
        end
        // emit one character beat per cycle as the reads return
        S_DUMP: begin
          if (more) begin
            idx <= idx + 1'b1;
          end
          if (pend) begin
            result_valid <= 1'b1;
            res <= make_res(ST_OK, LEN_W'(count), '0, rdata, 1'b1,
                            pend_a == AW'(count - 1'b1));
            if (pend_a == AW'(count - 1'b1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status        = res.status;
  assign length        = res.length;
  assign removed_count = res.removed_count;
  assign list_char     = res.list_char;
  assign item_valid    = res.item_valid;
  assign last          = res.last;

  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("list length exceeds capacity");

  // only dump character beats may be followed by more beats of the same command
  a_not_last_is_item: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> item_valid)
    else $error("non-final result beat without a character");

  // an append to a full list is dropped with the full status
  a_full_append: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == OP_APPEND && full |=> result_valid && status == ST_FULL)
    else $error("append to full list not flagged");

  // a pending read only exists while a command is in progress
  a_pend_busy: assert property (@(posedge clk) disable iff (rst) pend |-> busy)
    else $error("read return outside a command");

endmodule

@@ tb/sv/tb_ordered_char_list_engine.sv @@
// Self-checking testbench for ordered_char_list_engine: directed and random command beats,
// each result strobe compared with a list predictor kept in step at every accepted beat.
// Depends on ocl_pkg and the engine RTL under design/.
module tb_ordered_char_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ocl_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_BEATS = 240;
  localparam int REPORT_MAX   = 10;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              start      = 1'b0;
  logic [1:0]        op         = OP_APPEND;
  logic [CHAR_W-1:0] value_char = '0;
  logic [POS_W-1:0]  position   = '0;
  logic              busy;
  logic              result_valid;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  removed_count;
  logic [CHAR_W-1:0] list_char;
  logic              item_valid;
  logic              last;

  // Predicted list contents and the results still owed by the engine
  logic [CHAR_W-1:0] list_cells [0:CAPACITY-1];
  int                list_len = 0;
  res_t              results_due [$];

  int beats_sent = 0;
  int mismatches = 0;
  bit no_gaps    = 1'b0;

  logic [CHAR_W-1:0] few_chars [0:3] = '{8'h00, 8'hFF, 8'h41, 8'h7E};

  ordered_char_list_engine #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value_char   (value_char),
    .position     (position),
    .result_valid (result_valid),
    .status       (status),
    .length       (length),
    .removed_count(removed_count),
    .list_char    (list_char),
    .item_valid   (item_valid),
    .last         (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Queue one expected result, length taken after the operation
  function automatic void owe_result(logic [STAT_W-1:0] st, logic [LEN_W-1:0] removed,
                                     logic [CHAR_W-1:0] ch, logic valid, logic fin);
    res_t r;
    r.status        = st;
    r.length        = LEN_W'(list_len);
    r.removed_count = removed;
    r.list_char     = ch;
    r.item_valid    = valid;
    r.last          = fin;
    results_due.push_back(r);
  endfunction

  // Apply one command to the predicted list and queue what it yields
  function automatic void apply_list_op(op_t kind, logic [CHAR_W-1:0] ch,
                                        logic [POS_W-1:0] pos);
    int kept;
    int removed;
    case (kind)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          owe_result(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          list_cells[list_len] = ch;
          list_len++;
          owe_result(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_INSERT: begin
        // full check takes priority over the range check
        if (list_len >= CAPACITY) begin
          owe_result(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else if (int'(pos) > list_len) begin
          owe_result(ST_RANGE, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = ch;
          list_len++;
          owe_result(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      OP_REMOVE: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_cells[i] != ch) begin
            list_cells[kept] = list_cells[i];
            kept++;
          end
        end
        removed  = list_len - kept;
        list_len = kept;
        owe_result(ST_OK, LEN_W'(removed), '0, 1'b0, 1'b1);
      end
      default: begin
        // empty list still gives one marker beat
        if (list_len == 0) begin
          owe_result(ST_OK, '0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            owe_result(ST_OK, '0, list_cells[i], 1'b1, (i + 1 == list_len));
        end
      end
    endcase
  endfunction

  // Drive one command beat after a random idle gap; return at the accepting edge
  task automatic send_cmd(op_t kind, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= kind;
    value_char <= ch;
    position   <= pos;
    do @(posedge clk); while (busy);
    apply_list_op(kind, ch, pos);
    beats_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(bit narrow);
    return narrow ? few_chars[$urandom_range(0, 3)] : CHAR_W'($urandom_range(0, 255));
  endfunction

  // Prefer a character that is actually stored, so removes bite
  function automatic logic [CHAR_W-1:0] pick_stored(bit narrow);
    if (list_len > 0 && $urandom_range(0, 4) != 0)
      return list_cells[$urandom_range(0, list_len - 1)];
    return pick_char(narrow);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(bit in_range);
    if (in_range || list_len >= 255) return POS_W'($urandom_range(0, list_len));
    return POS_W'($urandom_range(list_len + 1, 255));
  endfunction

  // Compare each result strobe with the oldest expectation
  task automatic check_result;
    res_t got;
    res_t want;
    got.status        = status;
    got.length        = length;
    got.removed_count = removed_count;
    got.list_char     = list_char;
    got.item_valid    = item_valid;
    got.last          = last;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result: st %0d len %0d rm %0d ch %h v %0d l %0d",
                 got.status, got.length, got.removed_count, got.list_char, got.item_valid,
                 got.last);
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"mismatch: exp st %0d len %0d rm %0d ch %h v %0d l %0d,",
                    " got st %0d len %0d rm %0d ch %h v %0d l %0d"},
                   want.status, want.length, want.removed_count, want.list_char,
                   want.item_valid, want.last, got.status, got.length, got.removed_count,
                   got.list_char, got.item_valid, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) check_result();
  end

  // Empty list behaviour and the range check on a short list
  task automatic test_empty_list;
    send_cmd(OP_DUMP,   8'h00, 8'hFF);
    send_cmd(OP_REMOVE, 8'h00, 8'h00);
    send_cmd(OP_INSERT, 8'h12, 8'h01);
    send_cmd(OP_INSERT, 8'h34, 8'hFF);
    send_cmd(OP_INSERT, 8'hFF, 8'h00);
    send_cmd(OP_DUMP,   8'hFF, 8'h00);
    send_cmd(OP_REMOVE, 8'hFF, 8'hAA);
    send_cmd(OP_DUMP,   8'h55, 8'h55);
  endtask

  // Ordering of inserts at head, middle and tail; multi-hit and absent removes
  task automatic test_ordering;
    send_cmd(OP_APPEND, 8'h00, 8'hFF);
    send_cmd(OP_APPEND, 8'hFF, 8'h00);
    send_cmd(OP_INSERT, 8'hA5, 8'h01);
    send_cmd(OP_INSERT, 8'h5A, 8'h03);
    send_cmd(OP_INSERT, 8'h77, 8'h05);
    send_cmd(OP_INSERT, 8'h80, 8'h00);
    send_cmd(OP_DUMP,   8'h00, 8'h00);
    send_cmd(OP_REMOVE, 8'h11, 8'h00);
    send_cmd(OP_APPEND, 8'hA5, 8'h80);
    send_cmd(OP_REMOVE, 8'hA5, 8'h00);
    send_cmd(OP_DUMP,   8'h00, 8'h00);
    send_cmd(OP_REMOVE, 8'h00, 8'h00);
    send_cmd(OP_REMOVE, 8'hFF, 8'h00);
    send_cmd(OP_DUMP,   8'h00, 8'h00);
  endtask

  // Fill to capacity, then hit the full flag on append and insert
  task automatic test_full_list;
    while (list_len < CAPACITY) begin
      if ($urandom_range(0, 1)) send_cmd(OP_APPEND, pick_char(1'b0), POS_W'($urandom));
      else                      send_cmd(OP_INSERT, pick_char(1'b0), pick_pos(1'b1));
    end
    send_cmd(OP_APPEND, 8'hFF, 8'h00);
    send_cmd(OP_INSERT, 8'h00, 8'h00);
    send_cmd(OP_INSERT, 8'h00, 8'hFF);
    send_cmd(OP_DUMP,   8'h00, 8'h00);
    send_cmd(OP_REMOVE, pick_stored(1'b0), 8'h00);
    send_cmd(OP_DUMP,   8'h00, 8'h00);
  endtask

  // Phased random traffic: grow, shrink, mixed and noise, with gap-free bursts
  task automatic test_random_traffic;
    int first;
    int mode;
    int pick;
    int n;
    bit narrow;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      mode    = $urandom_range(0, 3);
      narrow  = $urandom_range(0, 1);
      no_gaps = ($urandom_range(0, 3) == 0);
      n       = $urandom_range(8, 40);
      repeat (n) begin
        pick = $urandom_range(0, 9);
        case (mode)
          0: begin
            if (pick < 5)      send_cmd(OP_APPEND, pick_char(narrow), POS_W'($urandom));
            else if (pick < 9) send_cmd(OP_INSERT, pick_char(narrow), pick_pos(pick != 8));
            else               send_cmd(OP_DUMP, pick_char(narrow), POS_W'($urandom));
          end
          1: begin
            if (pick < 6)      send_cmd(OP_REMOVE, pick_stored(narrow), POS_W'($urandom));
            else if (pick < 8) send_cmd(OP_APPEND, pick_char(narrow), POS_W'($urandom));
            else               send_cmd(OP_DUMP, pick_char(narrow), POS_W'($urandom));
          end
          2: begin
            case (pick % 4)
              0: send_cmd(OP_APPEND, pick_char(narrow), POS_W'($urandom));
              1: send_cmd(OP_INSERT, pick_char(narrow), pick_pos(pick < 8));
              2: send_cmd(OP_REMOVE, pick_stored(narrow), POS_W'($urandom));
              default: send_cmd(OP_DUMP, pick_char(narrow), POS_W'($urandom));
            endcase
          end
          default: begin
            send_cmd(op_t'($urandom_range(0, 3)), CHAR_W'($urandom), POS_W'($urandom));
          end
        endcase
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_ordering();
    test_full_list();
    test_random_traffic();
    start <= 1'b0;
    // drain outstanding results, then allow for any stray strobes
    while (results_due.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #500_000;
    $display("tb: failure");
    $finish;
  end

endmodule
